// ===== design/gcrf_pkg.sv =====
// Shared types and constants for the gamepad change report filter.
// No dependencies; the files that use it refer to it by scoped names.
package gcrf_pkg;

	localparam int AXES      = 6;
	localparam int BUTTONS   = 10;
	localparam int NUM_EVT   = 17;
	localparam int AXIS_BASE = 10;
	localparam int EVT_W     = 5;

	localparam logic [2:0] LAST_AXIS  = 3'(AXES - 1);
	localparam logic [2:0] AXIS_LTRIG = 3'd2;
	localparam logic [2:0] AXIS_RTRIG = 3'd5;

	localparam logic [15:0] FULL_SCALE   = 16'd32767;
	localparam logic [15:0] NEG_LIMIT    = 16'h8000;
	localparam logic [15:0] IDLE_TRIGGER = 16'h8001;

	localparam logic [1:0] ACT_CONNECT    = 2'd0;
	localparam logic [1:0] ACT_DISCONNECT = 2'd1;
	localparam logic [1:0] ACT_UPDATE     = 2'd2;

	localparam logic [2:0] EV_CONNECTED    = 3'd0;
	localparam logic [2:0] EV_DISCONNECTED = 3'd1;
	localparam logic [2:0] EV_BUTTON       = 3'd2;
	localparam logic [2:0] EV_AXIS         = 3'd3;
	localparam logic [2:0] EV_HAT          = 3'd4;

	localparam int CFG_ADDR_W = 4;
	localparam logic [CFG_ADDR_W-1:0] CFG_DEADZONE  = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 4'd1;

	localparam logic [14:0] DEADZONE_RST  = 15'd0;
	localparam logic [15:0] THRESHOLD_RST = 16'd1200;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CONN_WR,
		ST_AX_RD,
		ST_AX_CMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       load_conn;
		logic       load_disc;
		logic       load_upd;
		logic       conn_wr;
		logic       ax_rd;
		logic       ax_cmp;
		logic       emit;
		logic [2:0] ax_idx;
	} cmd_t;

	typedef struct packed {
		logic       pad_ok;
		logic       connected;
		logic [1:0] action;
		logic       out_free;
		logic       mask_empty;
		logic       mask_last;
	} sts_t;

endpackage

// ===== design/gcrf_if.sv =====
// Channel interfaces: report input, event output and register write port.
// Depends on nothing; widths follow the field list of the block.
interface gcrf_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [1:0]         pad_index;
	logic [9:0]         buttons;
	logic signed [15:0] axis_0;
	logic signed [15:0] axis_1;
	logic signed [15:0] axis_2;
	logic signed [15:0] axis_3;
	logic signed [15:0] axis_4;
	logic signed [15:0] axis_5;
	logic [3:0]         hat;

	modport source (output valid, action, pad_index, buttons, axis_0, axis_1, axis_2,
		axis_3, axis_4, axis_5, hat, input ready);
	modport sink (input valid, action, pad_index, buttons, axis_0, axis_1, axis_2,
		axis_3, axis_4, axis_5, hat, output ready);
endinterface

interface gcrf_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_kind;
	logic [1:0]         pad_id;
	logic [3:0]         element;
	logic signed [15:0] value;
	logic               last;

	modport source (output valid, event_kind, pad_id, element, value, last, input ready);
	modport sink (input valid, event_kind, pad_id, element, value, last, output ready);
endinterface

interface gcrf_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  addr;
	logic [15:0] wdata;

	modport source (output valid, addr, wdata, input ready);
	modport sink (input valid, addr, wdata, output ready);
endinterface

// ===== design/gamepad_change_report_filter.sv =====
// Gamepad change report filter. A report is taken only while the sequencer is idle.
// Ignored report: decide, then idle. Connect: decide, one history write per axis, then
// the event. Disconnect: decide, then the event. Update: decode and axis compare (one
// history memory port, read then compare per axis), then one event per cycle while the
// output register is free as it drains; the next report is taken in the cycle after the
// last event is loaded. arst_n clears connections, pending events, config to defaults.
module gamepad_change_report_filter #(
	parameter int NUM_PADS = 4
) (
	input logic         clk,
	input logic         arst_n,
	gcrf_in_if.sink     in_ch,
	gcrf_out_if.source  out_ch,
	gcrf_cfg_if.sink    cfg
);

	gcrf_pkg::cmd_t cmd;
	gcrf_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	gcrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.sts      (sts),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	gcrf_dpath #(
		.NUM_PADS (NUM_PADS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (in_ch.action),
		.pad_index  (in_ch.pad_index),
		.buttons    (in_ch.buttons),
		.axis_0     (in_ch.axis_0),
		.axis_1     (in_ch.axis_1),
		.axis_2     (in_ch.axis_2),
		.axis_3     (in_ch.axis_3),
		.axis_4     (in_ch.axis_4),
		.axis_5     (in_ch.axis_5),
		.hat        (in_ch.hat),
		.cfg_valid  (cfg.valid),
		.cfg_addr   (cfg.addr),
		.cfg_wdata  (cfg.wdata),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.event_kind (out_ch.event_kind),
		.pad_id     (out_ch.pad_id),
		.element    (out_ch.element),
		.value      (out_ch.value),
		.last       (out_ch.last)
	);

endmodule

// ===== design/gcrf_ctrl.sv =====
// Sequencer for the change report filter: decides, walks the axes, emits.
// Depends on gcrf_pkg for state, command and status types.
module gcrf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  gcrf_pkg::sts_t  sts,
	output logic            in_ready,
	output gcrf_pkg::cmd_t  cmd
);

	gcrf_pkg::state_t state_q, state_nx;
	logic [2:0]       cnt_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			gcrf_pkg::ST_IDLE: begin
				if (in_valid) state_nx = gcrf_pkg::ST_DECIDE;
			end
			gcrf_pkg::ST_DECIDE: begin
				state_nx = gcrf_pkg::ST_IDLE;
				if (sts.pad_ok) begin
					unique case (sts.action)
						gcrf_pkg::ACT_CONNECT: begin
							if (!sts.connected) state_nx = gcrf_pkg::ST_CONN_WR;
						end
						gcrf_pkg::ACT_DISCONNECT: begin
							if (sts.connected) state_nx = gcrf_pkg::ST_EMIT;
						end
						gcrf_pkg::ACT_UPDATE: begin
							if (sts.connected) state_nx = gcrf_pkg::ST_AX_RD;
						end
						default: state_nx = gcrf_pkg::ST_IDLE;
					endcase
				end
			end
			gcrf_pkg::ST_CONN_WR: begin
				if (cnt_q == gcrf_pkg::LAST_AXIS) state_nx = gcrf_pkg::ST_EMIT;
			end
			gcrf_pkg::ST_AX_RD: begin
				state_nx = gcrf_pkg::ST_AX_CMP;
			end
			gcrf_pkg::ST_AX_CMP: begin
				state_nx = (cnt_q == gcrf_pkg::LAST_AXIS) ? gcrf_pkg::ST_EMIT
					: gcrf_pkg::ST_AX_RD;
			end
			gcrf_pkg::ST_EMIT: begin
				if (sts.mask_empty || (sts.out_free && sts.mask_last))
					state_nx = gcrf_pkg::ST_IDLE;
			end
			default: state_nx = gcrf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.ax_idx = cnt_q;
		in_ready   = 1'b0;
		unique case (state_q)
			gcrf_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			gcrf_pkg::ST_DECIDE: begin
				cmd.load_conn = sts.pad_ok && (sts.action == gcrf_pkg::ACT_CONNECT)
					&& !sts.connected;
				cmd.load_disc = sts.pad_ok && (sts.action == gcrf_pkg::ACT_DISCONNECT)
					&& sts.connected;
				cmd.load_upd  = sts.pad_ok && (sts.action == gcrf_pkg::ACT_UPDATE)
					&& sts.connected;
			end
			gcrf_pkg::ST_CONN_WR: cmd.conn_wr = 1'b1;
			gcrf_pkg::ST_AX_RD:   cmd.ax_rd   = 1'b1;
			gcrf_pkg::ST_AX_CMP:  cmd.ax_cmp  = 1'b1;
			gcrf_pkg::ST_EMIT:    cmd.emit    = sts.out_free && !sts.mask_empty;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcrf_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == gcrf_pkg::ST_DECIDE) cnt_q <= '0;
			else if (state_q == gcrf_pkg::ST_CONN_WR || state_q == gcrf_pkg::ST_AX_CMP)
				cnt_q <= cnt_q + 3'd1;
		end
	end

endmodule

// ===== design/gcrf_dpath.sv =====
// Datapath: report registers, axis scaling, per-pad history, history memory,
// pending-event mask and the event output register. Depends on gcrf_pkg.
module gcrf_dpath #(
	parameter int NUM_PADS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gcrf_pkg::cmd_t     cmd,
	output gcrf_pkg::sts_t     sts,
	input  logic [1:0]         action,
	input  logic [1:0]         pad_index,
	input  logic [9:0]         buttons,
	input  logic signed [15:0] axis_0,
	input  logic signed [15:0] axis_1,
	input  logic signed [15:0] axis_2,
	input  logic signed [15:0] axis_3,
	input  logic signed [15:0] axis_4,
	input  logic signed [15:0] axis_5,
	input  logic [3:0]         hat,
	input  logic               cfg_valid,
	input  logic [3:0]         cfg_addr,
	input  logic [15:0]        cfg_wdata,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [2:0]         event_kind,
	output logic [1:0]         pad_id,
	output logic [3:0]         element,
	output logic signed [15:0] value,
	output logic               last
);

	localparam int PAD_W     = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
	localparam int MEM_DEPTH = NUM_PADS * 8;

	function automatic logic [15:0] scale_axis(input logic [2:0] ax, input logic [15:0] raw,
		input logic [14:0] dz);
		logic [15:0] s;
		logic [15:0] t2;
		logic [15:0] mag;
		s = (raw == gcrf_pkg::NEG_LIMIT) ? gcrf_pkg::IDLE_TRIGGER : raw;
		t2 = s[15] ? 16'd0 : {s[14:0], 1'b0};
		mag = s[15] ? (16'd0 - s) : s;
		if (ax == gcrf_pkg::AXIS_LTRIG || ax == gcrf_pkg::AXIS_RTRIG)
			return t2 - gcrf_pkg::FULL_SCALE;
		return (mag < {1'b0, dz}) ? 16'd0 : s;
	endfunction

	// config
	logic [14:0] dz_q;
	logic [15:0] thr_q;

	// report
	logic [1:0]  act_q;
	logic [1:0]  pad_q;
	logic [9:0]  buttons_q;
	logic [3:0]  hat_q;
	logic [15:0] raw_q    [gcrf_pkg::AXES];
	logic [15:0] scaled_q [gcrf_pkg::AXES];

	// history
	logic [NUM_PADS-1:0] conn_q;
	logic [9:0]          sent_btn_q [NUM_PADS];
	logic [3:0]          sent_hat_q [NUM_PADS];
	logic [15:0]         hist_mem   [MEM_DEPTH];
	logic [15:0]         hist_rd_q;

	logic [gcrf_pkg::NUM_EVT-1:0] mask_q;
	logic                         out_valid_q;
	logic [2:0]                   kind_q;
	logic [1:0]                   pad_evt_q;
	logic [3:0]                   elem_q;
	logic [15:0]                  value_q;
	logic                         last_q;

	logic [PAD_W-1:0]   pad_sel;
	logic [PAD_W+2:0]   mem_addr;
	logic [15:0]        scaled_sel;
	logic signed [16:0] diff;
	logic [16:0]        diff_mag;
	logic               moved;
	logic               mem_we;
	logic [15:0]        mem_wdata;
	logic [gcrf_pkg::EVT_W-1:0] evt_idx;
	logic [gcrf_pkg::EVT_W-1:0] ax_off;
	logic [2:0]         kind_nx;
	logic [3:0]         elem_nx;
	logic [15:0]        value_nx;
	logic               pad_ok;

	assign pad_sel  = PAD_W'(pad_q);
	assign mem_addr = {pad_sel, cmd.ax_idx};
	assign pad_ok   = (32'(pad_q) < NUM_PADS);

	assign sts.pad_ok     = pad_ok;
	assign sts.connected  = pad_ok && conn_q[pad_sel];
	assign sts.action     = act_q;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.mask_empty = (mask_q == '0);
	assign sts.mask_last  = ((mask_q & (mask_q - 1'b1)) == '0);

	assign scaled_sel = scaled_q[cmd.ax_idx];
	assign diff       = $signed({scaled_sel[15], scaled_sel}) - $signed({hist_rd_q[15], hist_rd_q});
	assign diff_mag   = diff[16] ? 17'(-diff) : 17'(diff);
	assign moved      = diff_mag > {1'b0, thr_q};

	assign mem_we    = cmd.conn_wr || (cmd.ax_cmp && moved);
	assign mem_wdata = cmd.conn_wr
		? ((cmd.ax_idx == gcrf_pkg::AXIS_LTRIG || cmd.ax_idx == gcrf_pkg::AXIS_RTRIG)
			? gcrf_pkg::IDLE_TRIGGER : 16'd0)
		: scaled_sel;

	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[mem_addr] <= mem_wdata;
		if (cmd.ax_rd) hist_rd_q <= hist_mem[mem_addr];
	end

	// lowest pending event goes first
	always_comb begin
		evt_idx = '0;
		for (int i = gcrf_pkg::NUM_EVT - 1; i >= 0; i--) begin
			if (mask_q[i]) evt_idx = gcrf_pkg::EVT_W'(i);
		end
	end

	assign ax_off = evt_idx - gcrf_pkg::EVT_W'(gcrf_pkg::AXIS_BASE);

	always_comb begin
		priority if (act_q == gcrf_pkg::ACT_CONNECT) begin
			kind_nx  = gcrf_pkg::EV_CONNECTED;
			elem_nx  = '0;
			value_nx = '0;
		end else if (act_q == gcrf_pkg::ACT_DISCONNECT) begin
			kind_nx  = gcrf_pkg::EV_DISCONNECTED;
			elem_nx  = '0;
			value_nx = '0;
		end else if (evt_idx < gcrf_pkg::EVT_W'(gcrf_pkg::AXIS_BASE)) begin
			kind_nx  = gcrf_pkg::EV_BUTTON;
			elem_nx  = evt_idx[3:0];
			value_nx = {15'd0, buttons_q[evt_idx[3:0]]};
		end else if (evt_idx == gcrf_pkg::EVT_W'(gcrf_pkg::NUM_EVT - 1)) begin
			kind_nx  = gcrf_pkg::EV_HAT;
			elem_nx  = '0;
			value_nx = {12'd0, hat_q};
		end else begin
			kind_nx  = gcrf_pkg::EV_AXIS;
			elem_nx  = 4'(ax_off);
			value_nx = scaled_q[ax_off[2:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q        <= gcrf_pkg::DEADZONE_RST;
			thr_q       <= gcrf_pkg::THRESHOLD_RST;
			conn_q      <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_addr == gcrf_pkg::CFG_DEADZONE) dz_q <= cfg_wdata[14:0];
			if (cfg_valid && cfg_addr == gcrf_pkg::CFG_THRESHOLD) thr_q <= cfg_wdata;

			if (cmd.load_conn) conn_q[pad_sel] <= 1'b1;
			if (cmd.load_disc) conn_q[pad_sel] <= 1'b0;

			if (cmd.load_conn || cmd.load_disc) begin
				mask_q <= gcrf_pkg::NUM_EVT'(1);
			end else if (cmd.load_upd) begin
				mask_q <= {(hat_q != sent_hat_q[pad_sel]), 6'd0,
					buttons_q ^ sent_btn_q[pad_sel]};
			end else if (cmd.ax_cmp && moved) begin
				mask_q[gcrf_pkg::AXIS_BASE + int'(cmd.ax_idx)] <= 1'b1;
			end else if (cmd.emit) begin
				mask_q <= mask_q & (mask_q - 1'b1);
			end

			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q     <= action;
			pad_q     <= pad_index;
			buttons_q <= buttons;
			hat_q     <= hat;
			raw_q[0]  <= axis_0;
			raw_q[1]  <= axis_1;
			raw_q[2]  <= axis_2;
			raw_q[3]  <= axis_3;
			raw_q[4]  <= axis_4;
			raw_q[5]  <= axis_5;
		end
		if (cmd.load_conn) begin
			sent_btn_q[pad_sel] <= '0;
			sent_hat_q[pad_sel] <= '0;
		end
		if (cmd.load_upd) begin
			sent_btn_q[pad_sel] <= buttons_q;
			sent_hat_q[pad_sel] <= hat_q;
			for (int i = 0; i < gcrf_pkg::AXES; i++) begin
				scaled_q[i] <= scale_axis(3'(i), raw_q[i], dz_q);
			end
		end
		// pad is held with the beat, the next report may be captured while it waits
		if (cmd.emit) begin
			kind_q    <= kind_nx;
			pad_evt_q <= pad_q;
			elem_q    <= elem_nx;
			value_q   <= value_nx;
			last_q    <= sts.mask_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign pad_id     = pad_evt_q;
	assign element    = elem_q;
	assign value      = $signed(value_q);
	assign last       = last_q;

endmodule

// ===== bench/gamepad_change_report_filter_tb.sv =====
// Self-checking bench for gamepad_change_report_filter: directed and random reports,
// predicted change events compared beat by beat. Uses gcrf_pkg and the gcrf_*_if channels.
`timescale 1ns / 100ps
module gamepad_change_report_filter_tb;

	localparam int          PADS       = 4;
	localparam int          HOLD_PAUSE = 40;
	localparam int          STALL_PCT  = 18;
	localparam logic [1:0]  ACT_UNUSED = 2'd3;
	localparam logic [3:0]  CFG_NONE   = 4'd7;

	typedef struct packed {
		logic [1:0]       action;
		logic [1:0]       pad;
		logic [9:0]       buttons;
		logic [5:0][15:0] axis;
		logic [3:0]       hat;
	} report_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  pad;
		logic [3:0]  element;
		logic [15:0] value;
		logic        last;
	} pad_event_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	int   mismatches = 0;

	gcrf_in_if  in_ch();
	gcrf_out_if out_ch();
	gcrf_cfg_if cfg_ch();

	gamepad_change_report_filter #(
		.NUM_PADS(PADS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg_ch)
	);

	// predictor state, mirrored register values
	logic       pad_linked[PADS];
	logic [9:0] held_buttons[PADS];
	int         held_axes[PADS][gcrf_pkg::AXES];
	logic [3:0] held_hat[PADS];
	int         dz_cfg;
	int         thr_cfg;

	pad_event_t pending_events[$];
	report_t    report_queue[$];
	report_t    on_wire;

	// stimulus-side shadow of which pads are up and what they last reported
	logic       gen_live[PADS];
	report_t    prev_in[PADS];

	always #6 clk = ~clk;

	function automatic int scaled_axis(int idx, logic [15:0] raw);
		int v;
		int mag;
		v = $signed(raw);
		if (v < -int'(gcrf_pkg::FULL_SCALE))
			v = -int'(gcrf_pkg::FULL_SCALE);
		if (idx == int'(gcrf_pkg::AXIS_LTRIG) || idx == int'(gcrf_pkg::AXIS_RTRIG)) begin
			if (v < 0)
				v = 0;
			return 2 * v - int'(gcrf_pkg::FULL_SCALE);
		end
		mag = (v < 0) ? -v : v;
		if (mag < dz_cfg)
			return 0;
		return v;
	endfunction

	function automatic pad_event_t make_event(logic [2:0] kind, int p, int elem, int val);
		pad_event_t ev;
		ev.kind    = kind;
		ev.pad     = 2'(p);
		ev.element = 4'(elem);
		ev.value   = 16'(val);
		ev.last    = 1'b0;
		return ev;
	endfunction

	function automatic void forecast_events(report_t r);
		pad_event_t burst[$];
		int         p;
		int         sc;
		int         diff;
		p = r.pad;
		case (r.action)
			gcrf_pkg::ACT_CONNECT: begin
				if (!pad_linked[p]) begin
					pad_linked[p]   = 1'b1;
					held_buttons[p] = '0;
					held_hat[p]     = '0;
					for (int i = 0; i < gcrf_pkg::AXES; i++)
						held_axes[p][i] = 0;
					held_axes[p][gcrf_pkg::AXIS_LTRIG] = -int'(gcrf_pkg::FULL_SCALE);
					held_axes[p][gcrf_pkg::AXIS_RTRIG] = -int'(gcrf_pkg::FULL_SCALE);
					burst.push_back(make_event(gcrf_pkg::EV_CONNECTED, p, 0, 0));
				end
			end
			gcrf_pkg::ACT_DISCONNECT: begin
				if (pad_linked[p]) begin
					burst.push_back(make_event(gcrf_pkg::EV_DISCONNECTED, p, 0, 0));
					pad_linked[p]   = 1'b0;
					held_buttons[p] = '0;
					held_hat[p]     = '0;
					for (int i = 0; i < gcrf_pkg::AXES; i++)
						held_axes[p][i] = 0;
				end
			end
			gcrf_pkg::ACT_UPDATE: begin
				if (pad_linked[p]) begin
					for (int i = 0; i < gcrf_pkg::BUTTONS; i++)
						if (r.buttons[i] != held_buttons[p][i]) begin
							held_buttons[p][i] = r.buttons[i];
							burst.push_back(make_event(gcrf_pkg::EV_BUTTON, p, i,
								int'(r.buttons[i])));
						end
					for (int i = 0; i < gcrf_pkg::AXES; i++) begin
						sc = scaled_axis(i, r.axis[i]);
						diff = sc - held_axes[p][i];
						if (diff < 0)
							diff = -diff;
						if (diff > thr_cfg) begin
							held_axes[p][i] = sc;
							burst.push_back(make_event(gcrf_pkg::EV_AXIS, p, i, sc));
						end
					end
					if (held_hat[p] != r.hat) begin
						held_hat[p] = r.hat;
						burst.push_back(make_event(gcrf_pkg::EV_HAT, p, 0, int'(r.hat)));
					end
				end
			end
			default: ;
		endcase
		if (burst.size() != 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[k])
			pending_events.push_back(burst[k]);
	endfunction

	// report driver
	always @(posedge clk) begin : drive_reports
		logic free;
		if (!arst_n) begin
			in_ch.valid     <= 1'b0;
			in_ch.action    <= '0;
			in_ch.pad_index <= '0;
			in_ch.buttons   <= '0;
			in_ch.axis_0    <= '0;
			in_ch.axis_1    <= '0;
			in_ch.axis_2    <= '0;
			in_ch.axis_3    <= '0;
			in_ch.axis_4    <= '0;
			in_ch.axis_5    <= '0;
			in_ch.hat       <= '0;
			for (int p = 0; p < PADS; p++) begin
				pad_linked[p]   = 1'b0;
				held_buttons[p] = '0;
				held_hat[p]     = '0;
				for (int i = 0; i < gcrf_pkg::AXES; i++)
					held_axes[p][i] = 0;
			end
		end else begin
			if (in_ch.valid && in_ch.ready)
				forecast_events(on_wire);
			free = !in_ch.valid || in_ch.ready;
			if (free) begin
				if (report_queue.size() != 0 && (steady || $urandom_range(99) >= STALL_PCT)) begin
					on_wire = report_queue.pop_front();
					in_ch.valid     <= 1'b1;
					in_ch.action    <= on_wire.action;
					in_ch.pad_index <= on_wire.pad;
					in_ch.buttons   <= on_wire.buttons;
					in_ch.axis_0    <= on_wire.axis[0];
					in_ch.axis_1    <= on_wire.axis[1];
					in_ch.axis_2    <= on_wire.axis[2];
					in_ch.axis_3    <= on_wire.axis[3];
					in_ch.axis_4    <= on_wire.axis[4];
					in_ch.axis_5    <= on_wire.axis[5];
					in_ch.hat       <= on_wire.hat;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// event monitor
	always @(posedge clk) begin : watch_events
		pad_event_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected event kind=%0d pad=%0d elem=%0d value=%0d last=%0b",
							$realtime, out_ch.event_kind, out_ch.pad_id, out_ch.element,
							out_ch.value, out_ch.last);
				end else begin
					want = pending_events.pop_front();
					if (out_ch.event_kind !== want.kind || out_ch.pad_id !== want.pad ||
						out_ch.element !== want.element || out_ch.value !== want.value ||
						out_ch.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: event mismatch exp kind=%0d pad=%0d elem=%0d value=%0d last=%0b got kind=%0d pad=%0d elem=%0d value=%0d last=%0b",
								$realtime, want.kind, want.pad, want.element,
								$signed(want.value), want.last, out_ch.event_kind,
								out_ch.pad_id, out_ch.element, out_ch.value, out_ch.last);
					end
				end
			end
			out_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
		end
	end

	function automatic report_t report_of(logic [1:0] act, int p, logic [9:0] btn,
		int a0, int a1, int a2, int a3, int a4, int a5, logic [3:0] hat);
		report_t r;
		r.action  = act;
		r.pad     = 2'(p);
		r.buttons = btn;
		r.axis[0] = 16'(a0);
		r.axis[1] = 16'(a1);
		r.axis[2] = 16'(a2);
		r.axis[3] = 16'(a3);
		r.axis[4] = 16'(a4);
		r.axis[5] = 16'(a5);
		r.hat     = hat;
		return r;
	endfunction

	// queue a report; returns 1 when the block will act on it
	function automatic bit post(report_t r);
		bit acts;
		acts = 1'b0;
		case (r.action)
			gcrf_pkg::ACT_CONNECT: begin
				acts = !gen_live[r.pad];
				gen_live[r.pad] = 1'b1;
			end
			gcrf_pkg::ACT_DISCONNECT: begin
				acts = gen_live[r.pad];
				gen_live[r.pad] = 1'b0;
			end
			gcrf_pkg::ACT_UPDATE: begin
				acts = gen_live[r.pad];
				prev_in[r.pad] = r;
			end
			default: ;
		endcase
		report_queue.push_back(r);
		return acts;
	endfunction

	function automatic report_t random_report();
		report_t r;
		int      p;
		int      roll;
		int      v;
		p = $urandom_range(PADS - 1);
		roll = $urandom_range(99);
		r = prev_in[p];
		r.pad = 2'(p);
		if (roll < 5)
			r.action = ACT_UNUSED;
		else if (!gen_live[p])
			r.action = (roll < 80) ? gcrf_pkg::ACT_CONNECT
				: ((roll < 90) ? gcrf_pkg::ACT_DISCONNECT : gcrf_pkg::ACT_UPDATE);
		else
			r.action = (roll < 86) ? gcrf_pkg::ACT_UPDATE
				: ((roll < 93) ? gcrf_pkg::ACT_DISCONNECT : gcrf_pkg::ACT_CONNECT);
		case ($urandom_range(3))
			0: r.buttons = 10'($urandom);
			1: r.buttons[$urandom_range(gcrf_pkg::BUTTONS - 1)] ^= 1'b1;
			2: begin
				r.buttons[$urandom_range(gcrf_pkg::BUTTONS - 1)] ^= 1'b1;
				r.buttons[$urandom_range(gcrf_pkg::BUTTONS - 1)] ^= 1'b1;
			end
			default: ;
		endcase
		for (int i = 0; i < gcrf_pkg::AXES; i++) begin
			case ($urandom_range(5))
				1: r.axis[i] = 16'(int'($signed(r.axis[i])) + int'($urandom_range(3000)) - 1500);
				2: r.axis[i] = 16'($urandom);
				3: begin
					case ($urandom_range(3))
						0: r.axis[i] = gcrf_pkg::NEG_LIMIT;
						1: r.axis[i] = gcrf_pkg::IDLE_TRIGGER;
						2: r.axis[i] = gcrf_pkg::FULL_SCALE;
						default: r.axis[i] = '0;
					endcase
				end
				4: begin
					// straddle the deadzone edge
					v = dz_cfg + int'($urandom_range(4)) - 2;
					if ($urandom_range(1))
						v = -v;
					r.axis[i] = 16'(v);
				end
				5: r.axis[i] = 16'(int'($urandom_range(4000)) - 2000);
				default: ;
			endcase
		end
		if ($urandom_range(2) == 0)
			r.hat = 4'($urandom);
		return r;
	endfunction

	task automatic random_run(int goal);
		int acted;
		acted = 0;
		while (acted < goal)
			if (post(random_report()))
				acted++;
	endtask

	// wait for every report taken and every event seen, then let the block settle
	task automatic drain();
		while (report_queue.size() != 0 || in_ch.valid || pending_events.size() != 0)
			@(negedge clk);
		repeat (HOLD_PAUSE) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.wdata <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == gcrf_pkg::CFG_DEADZONE)
			dz_cfg = int'(data[14:0]);
		else if (idx == gcrf_pkg::CFG_THRESHOLD)
			thr_cfg = int'(data);
	endtask

	initial begin : limit_guard
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int d;
		arst_n          = 1'b0;
		steady          = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.addr     = '0;
		cfg_ch.wdata    = '0;
		dz_cfg          = int'(gcrf_pkg::DEADZONE_RST);
		thr_cfg         = int'(gcrf_pkg::THRESHOLD_RST);
		for (int p = 0; p < PADS; p++) begin
			gen_live[p]     = 1'b0;
			prev_in[p]      = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored cases, extremes, full burst, threshold edge
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 1, 10'h3FF, 500, 500, 500, 500, 500, 500,
			4'hF)));
		void'(post(report_of(gcrf_pkg::ACT_DISCONNECT, 1, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(ACT_UNUSED, 0, 10'h3FF, 1, 1, 1, 1, 1, 1, 4'hF)));
		void'(post(report_of(gcrf_pkg::ACT_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_CONNECT, 0, 10'h155, 7, 7, 7, 7, 7, 7, 4'h5)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 0, 10'h3FF, 32767, -32768, 32767, -32768,
			32767, 32767, 4'hF)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 0, 10'h000, -32767, -32767, -32768, 32767,
			-32768, -1, 4'h0)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 0, 10'h000, -32767, -32767, -32768, 32767,
			-32768, -1, 4'h0)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 0, 10'h200, -31567, -31566, 600, 31567,
			-32768, 0, 4'h8)));
		void'(post(report_of(gcrf_pkg::ACT_CONNECT, 1, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_CONNECT, 2, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_CONNECT, 3, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 3, 10'h2AA, 1201, -1201, 1, 1200, -1200,
			16384, 4'h3)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 2, 10'h001, 0, 0, 0, 0, 0, 0, 4'h0)));
		void'(post(report_of(gcrf_pkg::ACT_DISCONNECT, 3, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 3, 10'h3FF, 9000, 9000, 9000, 9000, 9000,
			9000, 4'hC)));
		void'(post(report_of(ACT_UNUSED, 1, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_DISCONNECT, 2, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_CONNECT, 3, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 3, 10'h000, 0, 0, -32767, 0, 0, -32767,
			4'h0)));
		drain();

		// widest deadzone, zero threshold; upper data bit must be dropped
		write_reg(gcrf_pkg::CFG_DEADZONE, 16'hFFFF);
		write_reg(gcrf_pkg::CFG_THRESHOLD, 16'd0);
		write_reg(CFG_NONE, 16'($urandom));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 1, 10'h0F0, 32767, 32766, 1, -32767, -32766,
			2, 4'h1)));
		random_run(20);
		drain();

		// threshold at max: axes never fire
		write_reg(gcrf_pkg::CFG_DEADZONE, 16'd0);
		write_reg(gcrf_pkg::CFG_THRESHOLD, 16'hFFFF);
		random_run(15);
		drain();

		// mid settings, no idling on either side
		write_reg(gcrf_pkg::CFG_DEADZONE, 16'($urandom_range(4000, 12000)));
		write_reg(gcrf_pkg::CFG_THRESHOLD, 16'($urandom_range(3000)));
		steady = 1'b1;
		if (!gen_live[0])
			void'(post(report_of(gcrf_pkg::ACT_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 0, 10'h3FF, 32767, -32767, 32767, 32767,
			-32767, 32767, 4'hF)));
		d = dz_cfg;
		void'(post(report_of(gcrf_pkg::ACT_UPDATE, 0, 10'h000, d, -(d - 1), 0, -d, d - 1, 0,
			4'h0)));
		random_run(25);
		drain();
		steady = 1'b0;

		write_reg(gcrf_pkg::CFG_DEADZONE, 16'd8000);
		write_reg(gcrf_pkg::CFG_THRESHOLD, gcrf_pkg::THRESHOLD_RST);
		random_run(25);
		drain();

		if (mismatches == 0 && pending_events.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
design/gcrf_pkg.sv
design/gcrf_if.sv
design/gcrf_ctrl.sv
design/gcrf_dpath.sv
design/gamepad_change_report_filter.sv
bench/gamepad_change_report_filter_tb.sv
